// ===== rtl/baro_pressure_temp_compensation_assert.svh =====
// Assertion macros shared by the compensation block.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define BPTC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Invariant checked at every clock edge outside reset.
`define BPTC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ===== rtl/bptc_pkg.sv =====
package bptc_pkg;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_SENS        = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SENS_TEMP   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET_TEMP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_REF_TEMP    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TEMP_SENS   = 3'd5;

  localparam logic signed [18:0] TEMP_BASE    = 19'sd2000;
  // Deviation from 20.00 C below which the extra cold term applies (-15.00 C).
  localparam logic signed [18:0] COLD_DEV     = 19'sd3500;
  localparam logic signed [18:0] TEMP_MIN     = -19'sd4000;
  localparam logic signed [18:0] TEMP_MAX     = 19'sd8500;
  localparam logic signed [26:0] PRESS_MIN    = 27'sd1000;
  localparam logic signed [26:0] PRESS_MAX    = 27'sd120000;

  typedef struct packed {
    logic [15:0] sens_coeff;
    logic [15:0] offset_coeff;
    logic [15:0] sens_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] reference_temp;
    logic [15:0] temp_sens_coeff;
  } coef_t;

  // First-order terms. temp_dev is TEMP - 2000; t2 is already zero when warm.
  typedef struct packed {
    logic [23:0]        raw_press;
    logic signed [17:0] temp_dev;
    logic [16:0]        t2;
    logic signed [34:0] off1;
    logic signed [33:0] sens1;
  } first_t;

  typedef struct packed {
    logic [23:0]        raw_press;
    logic signed [14:0] temp_centi;
    logic signed [38:0] off;
    logic signed [37:0] sens;
  } second_t;

endpackage

// ===== rtl/bptc_first_order.sv =====
module bptc_first_order (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bptc_pkg::coef_t  coef_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [23:0]      raw_press_i,
  input  logic [23:0]      raw_temp_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bptc_pkg::first_t out_data_o
);

  logic [2:0] v_q;
  logic [2:0] adv;

  logic signed [24:0] dt_d, dt_q;
  logic [23:0]        d1_s1_q, d1_s2_q;
  logic signed [40:0] m_t_d, m_t_q;
  logic signed [40:0] m_o_d, m_o_q;
  logic signed [40:0] m_s_d, m_s_q;
  logic [47:0]        m_d_d, m_d_q;
  logic signed [17:0] dev;
  bptc_pkg::first_t   res_d, res_q;

  assign adv[2] = !v_q[2] || out_ready_i;
  assign adv[1] = !v_q[1] || adv[2];
  assign adv[0] = !v_q[0] || adv[1];
  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[2];
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (adv[1]) begin
        v_q[1] <= v_q[0];
      end
      if (adv[2]) begin
        v_q[2] <= v_q[1];
      end
    end
  end

  assign dt_d = $signed({1'b0, raw_temp_i}) - $signed({1'b0, coef_i.reference_temp, 8'b0});

  assign m_t_d = 41'(dt_q * $signed({1'b0, coef_i.temp_sens_coeff}));
  assign m_o_d = 41'(dt_q * $signed({1'b0, coef_i.offset_temp_coeff}));
  assign m_s_d = 41'(dt_q * $signed({1'b0, coef_i.sens_temp_coeff}));
  assign m_d_d = 48'(dt_q * dt_q);

  always_comb begin
    dev               = 18'(m_t_q >>> 23);
    res_d.raw_press   = d1_s2_q;
    res_d.temp_dev    = dev;
    // The squared-difference correction only applies below 20.00 C.
    res_d.t2          = dev[17] ? m_d_q[47:31] : '0;
    res_d.off1        = 35'($signed({1'b0, coef_i.offset_coeff, 16'b0}))
                        + 35'(m_o_q >>> 7);
    res_d.sens1       = 34'($signed({1'b0, coef_i.sens_coeff, 15'b0}))
                        + 34'(m_s_q >>> 8);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dt_q    <= dt_d;
      d1_s1_q <= raw_press_i;
    end
    if (adv[1]) begin
      m_t_q   <= m_t_d;
      m_o_q   <= m_o_d;
      m_s_q   <= m_s_d;
      m_d_q   <= m_d_d;
      d1_s2_q <= d1_s1_q;
    end
    if (adv[2]) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/bptc_second_order.sv =====
module bptc_second_order (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bptc_pkg::first_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bptc_pkg::second_t out_data_o
);

  logic [2:0] v_q;
  logic [2:0] adv;

  logic signed [18:0] cold_dev;
  logic signed [17:0] x_sel, b_sel;
  logic [33:0]        sq_d, sq_q, sq2_d, sq2_q;
  logic signed [18:0] temp1_d, temp1_q;
  logic [23:0]        d1_a_q, d1_b_q;
  logic signed [34:0] off1_a_q, off1_b_q;
  logic signed [33:0] sens1_a_q, sens1_b_q;
  logic [36:0]        sq5;
  logic [37:0]        sq2_7, sq2_11;
  logic [37:0]        off2_d, off2_q;
  logic [36:0]        sens2_d, sens2_q;
  logic signed [14:0] temp_d, temp_q;
  bptc_pkg::second_t  res_d, res_q;

  assign adv[2] = !v_q[2] || out_ready_i;
  assign adv[1] = !v_q[1] || adv[2];
  assign adv[0] = !v_q[0] || adv[1];
  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[2];
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (adv[1]) begin
        v_q[1] <= v_q[0];
      end
      if (adv[2]) begin
        v_q[2] <= v_q[1];
      end
    end
  end

  // Zeroing the square operands when warm makes both corrections vanish.
  always_comb begin
    cold_dev = 19'(in_data_i.temp_dev) + bptc_pkg::COLD_DEV;
    x_sel    = in_data_i.temp_dev[17] ? in_data_i.temp_dev : '0;
    b_sel    = cold_dev[18] ? 18'(cold_dev) : '0;
    sq_d     = 34'(x_sel * x_sel);
    sq2_d    = 34'(b_sel * b_sel);
    temp1_d  = bptc_pkg::TEMP_BASE + 19'(in_data_i.temp_dev)
               - $signed({2'b0, in_data_i.t2});
  end

  always_comb begin
    sq5     = {1'b0, sq_q, 2'b0} + {3'b0, sq_q};
    sq2_7   = {1'b0, sq2_q, 3'b0} - {4'b0, sq2_q};
    sq2_11  = {1'b0, sq2_q, 3'b0} + {3'b0, sq2_q, 1'b0} + {4'b0, sq2_q};
    off2_d  = {2'b0, sq5[36:1]} + sq2_7;
    sens2_d = {2'b0, sq5[36:2]} + sq2_11[37:1];
    if (temp1_q < bptc_pkg::TEMP_MIN) begin
      temp_d = 15'(bptc_pkg::TEMP_MIN);
    end else if (temp1_q > bptc_pkg::TEMP_MAX) begin
      temp_d = 15'(bptc_pkg::TEMP_MAX);
    end else begin
      temp_d = 15'(temp1_q);
    end
  end

  always_comb begin
    res_d.raw_press  = d1_b_q;
    res_d.temp_centi = temp_q;
    res_d.off        = 39'(off1_b_q) - $signed({1'b0, off2_q});
    res_d.sens       = 38'(sens1_b_q) - $signed({1'b0, sens2_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      sq_q      <= sq_d;
      sq2_q     <= sq2_d;
      temp1_q   <= temp1_d;
      d1_a_q    <= in_data_i.raw_press;
      off1_a_q  <= in_data_i.off1;
      sens1_a_q <= in_data_i.sens1;
    end
    if (adv[1]) begin
      off2_q    <= off2_d;
      sens2_q   <= sens2_d;
      temp_q    <= temp_d;
      d1_b_q    <= d1_a_q;
      off1_b_q  <= off1_a_q;
      sens1_b_q <= sens1_a_q;
    end
    if (adv[2]) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/bptc_press_calc.sv =====
module bptc_press_calc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bptc_pkg::second_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [14:0] temp_centi_o,
  output logic [16:0]        press_centi_o
);

  logic [2:0] v_q;
  logic [2:0] adv;

  logic signed [18:0] sens_hi;
  logic [18:0]        sens_lo;
  logic [42:0]        pl_d, pl_q;
  logic signed [43:0] ph_d, ph_q;
  logic signed [61:0] prod;
  logic signed [40:0] q_d, q_q;
  logic signed [38:0] off_a_q, off_b_q;
  logic signed [14:0] temp_a_q, temp_b_q, temp_q;
  logic signed [41:0] r;
  logic signed [26:0] p;
  logic [16:0]        press_d, press_q;

  assign adv[2] = !v_q[2] || out_ready_i;
  assign adv[1] = !v_q[1] || adv[2];
  assign adv[0] = !v_q[0] || adv[1];
  assign in_ready_o    = adv[0];
  assign out_valid_o   = v_q[2];
  assign temp_centi_o  = temp_q;
  assign press_centi_o = press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      if (adv[1]) begin
        v_q[1] <= v_q[0];
      end
      if (adv[2]) begin
        v_q[2] <= v_q[1];
      end
    end
  end

  // The raw pressure times sensitivity product is split into two partial
  // products on the sensitivity's low and high halves.
  always_comb begin
    sens_lo = in_data_i.sens[18:0];
    sens_hi = in_data_i.sens[37:19];
    pl_d    = 43'(in_data_i.raw_press * sens_lo);
    ph_d    = 44'(sens_hi * $signed({1'b0, in_data_i.raw_press}));
  end

  always_comb begin
    prod = ($signed(62'(ph_q)) <<< 19) + $signed({19'b0, pl_q});
    q_d  = 41'(prod >>> 21);
  end

  always_comb begin
    r = 42'(q_q) - 42'(off_b_q);
    p = 27'(r >>> 15);
    if (p < bptc_pkg::PRESS_MIN) begin
      press_d = 17'(bptc_pkg::PRESS_MIN);
    end else if (p > bptc_pkg::PRESS_MAX) begin
      press_d = 17'(bptc_pkg::PRESS_MAX);
    end else begin
      press_d = 17'(p);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      pl_q     <= pl_d;
      ph_q     <= ph_d;
      off_a_q  <= in_data_i.off;
      temp_a_q <= in_data_i.temp_centi;
    end
    if (adv[1]) begin
      q_q      <= q_d;
      off_b_q  <= off_a_q;
      temp_b_q <= temp_a_q;
    end
    if (adv[2]) begin
      press_q <= press_d;
      temp_q  <= temp_b_q;
    end
  end

endmodule

// ===== rtl/baro_pressure_temp_compensation.sv =====
// Throughput: one transaction per cycle while the output is not stalled; nine register stages, with the
// sensitivity product split into two partial products over two of them.
// A stalled output holds its stage and back-pressure fills bubbles upstream first.
// Reset clears all stage valid bits and the six calibration registers to zero.
`include "baro_pressure_temp_compensation_assert.svh"

module baro_pressure_temp_compensation (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bptc_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [bptc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [23:0]                         raw_press_i,
  input  logic [23:0]                         raw_temp_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [14:0]                  temp_centi_o,
  output logic [16:0]                         press_centi_o
);

  bptc_pkg::coef_t   coef_q;
  bptc_pkg::first_t  first_data;
  bptc_pkg::second_t second_data;
  logic              first_valid, first_ready;
  logic              second_valid, second_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bptc_pkg::REG_SENS:        coef_q.sens_coeff        <= cfg_wdata_i;
        bptc_pkg::REG_OFFSET:      coef_q.offset_coeff      <= cfg_wdata_i;
        bptc_pkg::REG_SENS_TEMP:   coef_q.sens_temp_coeff   <= cfg_wdata_i;
        bptc_pkg::REG_OFFSET_TEMP: coef_q.offset_temp_coeff <= cfg_wdata_i;
        bptc_pkg::REG_REF_TEMP:    coef_q.reference_temp    <= cfg_wdata_i;
        bptc_pkg::REG_TEMP_SENS:   coef_q.temp_sens_coeff   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  bptc_first_order u_first (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .raw_press_i (raw_press_i),
    .raw_temp_i  (raw_temp_i),
    .out_valid_o (first_valid),
    .out_ready_i (first_ready),
    .out_data_o  (first_data)
  );

  bptc_second_order u_second (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (first_valid),
    .in_ready_o  (first_ready),
    .in_data_i   (first_data),
    .out_valid_o (second_valid),
    .out_ready_i (second_ready),
    .out_data_o  (second_data)
  );

  bptc_press_calc u_press (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (second_valid),
    .in_ready_o    (second_ready),
    .in_data_i     (second_data),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .temp_centi_o  (temp_centi_o),
    .press_centi_o (press_centi_o)
  );

  `BPTC_ASSERT_IMPL(a_temp_range, clk_i, rst_ni, out_valid_o,
    temp_centi_o >= -15'sd4000 && temp_centi_o <= 15'sd8500, "temperature out of range")
  `BPTC_ASSERT_IMPL(a_press_range, clk_i, rst_ni, out_valid_o,
    press_centi_o >= 17'd1000 && press_centi_o <= 17'd120000, "pressure out of range")
  `BPTC_ASSERT_ALWAYS(a_ready_when_drained, clk_i, rst_ni, in_ready_o || out_valid_o,
    "input stalled although no result is waiting")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned MAX_PRINTS = 50;

  // Indexes past the register file; writes to them must not disturb anything.
  localparam logic [bptc_pkg::CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [bptc_pkg::CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

  // Calibration sets used by the directed table.
  localparam logic [2:0] CAL_RESET   = 3'd0;
  localparam logic [2:0] CAL_TYPICAL = 3'd1;
  localparam logic [2:0] CAL_ALL_MAX = 3'd2;
  localparam logic [2:0] CAL_COLD    = 3'd3;
  localparam logic [2:0] CAL_CLEARED = 3'd4;

  localparam logic [23:0] RAW_MAX = 24'hFFFFFF;
  localparam logic [23:0] PRESS_TYP = 24'd9085466;
  localparam logic [23:0] TEMP_TYP = 24'd8569150;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic [16:0]        press_centi;
  } reading_t;

  typedef struct packed {
    logic [2:0]  cal_sel;
    logic [23:0] press;
    logic [23:0] temp;
    logic        fixed;
    reading_t    want;
  } vector_t;

  // With all coefficients zero the temperature sits at 20.00 C and the
  // pressure clamps to its floor, whatever the raw inputs are.
  localparam reading_t AT_ZERO_CAL = {15'sd2000, 17'd1000};
  localparam reading_t NO_WANT = '0;

  localparam int unsigned NUM_DIRECTED = 21;

  vector_t directed_vecs [NUM_DIRECTED] = '{
    {CAL_RESET,   24'd0,      24'd0,      1'b1, AT_ZERO_CAL},
    {CAL_RESET,   RAW_MAX,    RAW_MAX,    1'b1, AT_ZERO_CAL},
    {CAL_RESET,   24'hAAAAAA, 24'h555555, 1'b1, AT_ZERO_CAL},
    {CAL_RESET,   24'h555555, 24'hAAAAAA, 1'b1, AT_ZERO_CAL},
    {CAL_TYPICAL, PRESS_TYP,  TEMP_TYP,   1'b0, NO_WANT},
    {CAL_TYPICAL, PRESS_TYP,  24'd8000000, 1'b0, NO_WANT},
    {CAL_TYPICAL, PRESS_TYP,  24'd6000000, 1'b0, NO_WANT},
    {CAL_TYPICAL, PRESS_TYP,  24'd0,      1'b0, NO_WANT},
    {CAL_TYPICAL, 24'd0,      TEMP_TYP,   1'b0, NO_WANT},
    {CAL_TYPICAL, RAW_MAX,    TEMP_TYP,   1'b0, NO_WANT},
    {CAL_TYPICAL, RAW_MAX,    RAW_MAX,    1'b0, NO_WANT},
    {CAL_TYPICAL, 24'd0,      24'd0,      1'b0, NO_WANT},
    {CAL_TYPICAL, PRESS_TYP,  24'd8566784, 1'b0, NO_WANT},
    {CAL_TYPICAL, PRESS_TYP,  24'd8566783, 1'b0, NO_WANT},
    {CAL_ALL_MAX, RAW_MAX,    RAW_MAX,    1'b0, NO_WANT},
    {CAL_ALL_MAX, 24'd0,      24'd0,      1'b0, NO_WANT},
    {CAL_ALL_MAX, RAW_MAX,    24'd0,      1'b0, NO_WANT},
    {CAL_COLD,    PRESS_TYP,  24'd0,      1'b0, NO_WANT},
    {CAL_COLD,    RAW_MAX,    24'h800000, 1'b0, NO_WANT},
    {CAL_CLEARED, RAW_MAX,    RAW_MAX,    1'b1, AT_ZERO_CAL},
    {CAL_CLEARED, 24'h123456, 24'hFEDCBA, 1'b1, AT_ZERO_CAL}
  };

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [bptc_pkg::CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [bptc_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [23:0]                     raw_press_i = '0;
  logic [23:0]                     raw_temp_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic signed [14:0]              temp_centi_o;
  logic [16:0]                     press_centi_o;

  logic hold_req = 1'b0;
  logic quiet_tail = 1'b0;

  bptc_pkg::coef_t cal = '0;
  reading_t        expected_readings [$];
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;
  int unsigned     tx_calm = 0;

  baro_pressure_temp_compensation dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_press_i  (raw_press_i),
    .raw_temp_i   (raw_temp_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .temp_centi_o (temp_centi_o),
    .press_centi_o(press_centi_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bptc_pkg::coef_t cal_set(logic [2:0] sel);
    case (sel)
      CAL_TYPICAL: return {16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
      CAL_ALL_MAX: return '1;
      CAL_COLD:    return {16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'hFFFF, 16'hFFFF};
      default:     return '0;
    endcase
  endfunction

  function automatic logic [15:0] pick_coeff(logic [15:0] typical);
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return typical + 16'($urandom_range(0, 8191)) - 16'd4096;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Datasheet integer compensation with floor shifts on signed 64-bit values.
  function automatic reading_t compensate(logic [23:0] d1_raw, logic [23:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, t2, off2, sens2, dev, sq, cold, p;
    reading_t res;
    d1 = d1_raw;
    d2 = d2_raw;
    c1 = cal.sens_coeff;
    c2 = cal.offset_coeff;
    c3 = cal.sens_temp_coeff;
    c4 = cal.offset_temp_coeff;
    c5 = cal.reference_temp;
    c6 = cal.temp_sens_coeff;
    dt = d2 - c5 * 256;
    temp = 2000 + ((dt * c6) >>> 23);
    off = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    t2 = 0;
    off2 = 0;
    sens2 = 0;
    if (temp < 2000) begin
      dev = temp - 2000;
      sq = dev * dev;
      t2 = (dt * dt) >>> 31;
      off2 = (5 * sq) >>> 1;
      sens2 = (5 * sq) >>> 2;
      // The extra cold term keys off the first-order temperature as well.
      if (temp < -1500) begin
        cold = temp + 1500;
        off2 += 7 * cold * cold;
        sens2 += (11 * cold * cold) >>> 1;
      end
    end
    temp -= t2;
    off -= off2;
    sens -= sens2;
    p = (((d1 * sens) >>> 21) - off) >>> 15;
    if (temp < -4000) temp = -4000;
    if (temp > 8500) temp = 8500;
    if (p < 1000) p = 1000;
    if (p > 120000) p = 120000;
    res.temp_centi = temp[14:0];
    res.press_centi = p[16:0];
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("%0t MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(logic [bptc_pkg::CFG_ADDR_W-1:0] idx,
                           logic [bptc_pkg::CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      bptc_pkg::REG_SENS:        cal.sens_coeff = val;
      bptc_pkg::REG_OFFSET:      cal.offset_coeff = val;
      bptc_pkg::REG_SENS_TEMP:   cal.sens_temp_coeff = val;
      bptc_pkg::REG_OFFSET_TEMP: cal.offset_temp_coeff = val;
      bptc_pkg::REG_REF_TEMP:    cal.reference_temp = val;
      bptc_pkg::REG_TEMP_SENS:   cal.temp_sens_coeff = val;
      default: ;
    endcase
  endtask

  // Calibration only changes once the pipeline has drained completely.
  task automatic load_calibration(bptc_pkg::coef_t c);
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    write_reg(bptc_pkg::REG_SENS, c.sens_coeff);
    write_reg(bptc_pkg::REG_OFFSET, c.offset_coeff);
    write_reg(bptc_pkg::REG_SENS_TEMP, c.sens_temp_coeff);
    write_reg(bptc_pkg::REG_OFFSET_TEMP, c.offset_temp_coeff);
    write_reg(bptc_pkg::REG_REF_TEMP, c.reference_temp);
    write_reg(bptc_pkg::REG_TEMP_SENS, c.temp_sens_coeff);
    write_reg(REG_SPARE_A, 16'($urandom_range(0, 65535)));
    write_reg(REG_SPARE_B, 16'($urandom_range(0, 65535)));
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(logic [23:0] press, logic [23:0] temp, reading_t want);
    int unsigned pick;
    int unsigned gap;
    gap = 0;
    if (!quiet_tail) begin
      if (tx_calm != 0) begin
        tx_calm--;
      end else begin
        pick = $urandom_range(0, 15);
        if (pick < 3) gap = $urandom_range(1, 13);
        else if (pick == 3) tx_calm = $urandom_range(10, 40);
      end
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_press_i <= press;
    raw_temp_i <= temp;
    do @(posedge clk_i); while (!in_ready_o);
    expected_readings.push_back(want);
  endtask

  // Result side: check every transaction, then choose next cycle's ready.
  int unsigned rx_gap = 0;
  int unsigned rx_calm = 0;
  int unsigned hold_count = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin
    reading_t want;
    int unsigned pick;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readings.size() == 0) begin
        flag_mismatch($sformatf("unexpected result temp %0d press %0d",
                                temp_centi_o, press_centi_o));
      end else begin
        want = expected_readings.pop_front();
        if (temp_centi_o !== want.temp_centi)
          flag_mismatch($sformatf("temp_centi %0d, expected %0d",
                                  temp_centi_o, want.temp_centi));
        if (press_centi_o !== want.press_centi)
          flag_mismatch($sformatf("press_centi %0d, expected %0d",
                                  press_centi_o, want.press_centi));
      end
    end
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_count = HOLD_CYCLES;
    end
    if (hold_count != 0) begin
      hold_count--;
      out_ready_i <= 1'b0;
    end else if (quiet_tail) begin
      out_ready_i <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap--;
      out_ready_i <= 1'b0;
    end else if (rx_calm != 0) begin
      rx_calm--;
      out_ready_i <= 1'b1;
    end else begin
      pick = $urandom_range(0, 15);
      if (pick < 3) begin
        rx_gap = $urandom_range(1, 13) - 1;
        out_ready_i <= 1'b0;
      end else begin
        if (pick == 3) rx_calm = $urandom_range(20, 80);
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [2:0]      cur_sel;
    reading_t        want;
    bptc_pkg::coef_t rnd_cal;
    longint          tv;
    logic [23:0]     press;
    logic [23:0]     temp;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_sel = CAL_RESET;
    foreach (directed_vecs[i]) begin
      if (directed_vecs[i].cal_sel != cur_sel) begin
        cur_sel = directed_vecs[i].cal_sel;
        load_calibration(cal_set(cur_sel));
      end
      want = directed_vecs[i].fixed ? directed_vecs[i].want
                                    : compensate(directed_vecs[i].press, directed_vecs[i].temp);
      send_item(directed_vecs[i].press, directed_vecs[i].temp, want);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      rnd_cal.sens_coeff = pick_coeff(16'd40127);
      rnd_cal.offset_coeff = pick_coeff(16'd36924);
      rnd_cal.sens_temp_coeff = pick_coeff(16'd23317);
      rnd_cal.offset_temp_coeff = pick_coeff(16'd23282);
      rnd_cal.reference_temp = pick_coeff(16'd33464);
      rnd_cal.temp_sens_coeff = pick_coeff(16'd28312);
      load_calibration(rnd_cal);
      if (phase == 2) hold_req <= 1'b1;
      if (phase == RANDOM_PHASES - 1) quiet_tail <= 1'b1;
      repeat (ITEMS_PER_PHASE) begin
        case ($urandom_range(0, 3))
          0: press = 24'($urandom_range(0, RAW_MAX));
          1: press = PRESS_TYP + 24'($urandom_range(0, 2097152)) - 24'd1048576;
          2: press = $urandom_range(0, 1) ? RAW_MAX : 24'd0;
          default: press = 24'($urandom_range(0, RAW_MAX));
        endcase
        // Raw temperature is steered around the reference point so that warm,
        // cold and very cold readings all show up often.
        tv = longint'(cal.reference_temp) * 256;
        case ($urandom_range(0, 4))
          0: tv = longint'($urandom_range(0, RAW_MAX));
          1: tv = tv + longint'($urandom_range(0, 8191)) - 4096;
          2: tv = tv - longint'($urandom_range(0, 4194304));
          3: tv = $urandom_range(0, 1) ? longint'(RAW_MAX) : 0;
          default: tv = tv + longint'($urandom_range(0, 1048576));
        endcase
        if (tv < 0) tv = 0;
        if (tv > longint'(RAW_MAX)) tv = longint'(RAW_MAX);
        temp = tv[23:0];
        send_item(press, temp, compensate(press, temp));
      end
    end

    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
